// ----- hdl/pcfu_pkg.sv -----
// ----------------------------------------------------------------------------
// pcfu_pkg
// Shared types, constants and the parameter-count table for the packed
// command FIFO unpacker.
// ----------------------------------------------------------------------------
package pcfu_pkg;

    localparam int CMDS_PER_WORD = 4;
    localparam int CMD_W         = 8;
    localparam int WORD_W        = 32;
    localparam int IDX_W         = 5;
    localparam int NEED_W        = 6;
    localparam int POS_W         = $clog2(CMDS_PER_WORD + 1);
    localparam int QIDX_W        = $clog2(CMDS_PER_WORD);
    localparam int M_TDATA_W     = 48;

    // Command codes with a parameter count other than one
    localparam logic [CMD_W-1:0] CMD_NOP        = 8'h00;
    localparam logic [CMD_W-1:0] CMD_MTX_PUSH   = 8'h11;
    localparam logic [CMD_W-1:0] CMD_MTX_IDENT  = 8'h15;
    localparam logic [CMD_W-1:0] CMD_MTX_LOAD44 = 8'h16;
    localparam logic [CMD_W-1:0] CMD_MTX_LOAD43 = 8'h17;
    localparam logic [CMD_W-1:0] CMD_MTX_MUL44  = 8'h18;
    localparam logic [CMD_W-1:0] CMD_MTX_MUL43  = 8'h19;
    localparam logic [CMD_W-1:0] CMD_MTX_MUL33  = 8'h1A;
    localparam logic [CMD_W-1:0] CMD_MTX_SCALE  = 8'h1B;
    localparam logic [CMD_W-1:0] CMD_MTX_TRANS  = 8'h1C;
    localparam logic [CMD_W-1:0] CMD_VTX_16     = 8'h23;
    localparam logic [CMD_W-1:0] CMD_SHIN_TABLE = 8'h34;
    localparam logic [CMD_W-1:0] CMD_END_VTXS   = 8'h41;
    localparam logic [CMD_W-1:0] CMD_BOX_TEST   = 8'h70;
    localparam logic [CMD_W-1:0] CMD_POS_TEST   = 8'h71;

    typedef struct packed {
        logic is_plain;   // command takes no parameters
        logic done;       // current parameter completes the command
    } need_res_t;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic              has_param;
        logic [WORD_W-1:0] param_word;
        logic [IDX_W-1:0]  param_index;
        logic              command_done;
    } result_t;

    function automatic logic [NEED_W-1:0] needed_params(input logic [CMD_W-1:0] op);
        logic [NEED_W-1:0] n;
        case (op)
            CMD_NOP, CMD_MTX_PUSH, CMD_MTX_IDENT, CMD_END_VTXS: n = 6'd0;
            CMD_MTX_LOAD44, CMD_MTX_MUL44:                      n = 6'd16;
            CMD_MTX_LOAD43, CMD_MTX_MUL43:                      n = 6'd12;
            CMD_MTX_MUL33:                                      n = 6'd9;
            CMD_MTX_SCALE, CMD_MTX_TRANS, CMD_BOX_TEST:         n = 6'd3;
            CMD_VTX_16, CMD_POS_TEST:                           n = 6'd2;
            CMD_SHIN_TABLE:                                     n = 6'd32;
            default:                                            n = 6'd1;
        endcase
        return n;
    endfunction

endpackage

// ----- hdl/pcfu_need.sv -----
// ----------------------------------------------------------------------------
// pcfu_need
// Shared lookup/compare unit: parameter count of a command and the
// end-of-command test for the parameter at a given index.
// ----------------------------------------------------------------------------
module pcfu_need (
    input  logic [pcfu_pkg::CMD_W-1:0] op,
    input  logic [pcfu_pkg::IDX_W-1:0] idx,
    output pcfu_pkg::need_res_t        res
);

    logic [pcfu_pkg::NEED_W-1:0] need;
    logic [pcfu_pkg::NEED_W-1:0] idx_inc;

    assign need    = pcfu_pkg::needed_params(op);
    assign idx_inc = pcfu_pkg::NEED_W'(idx) + 1'b1;

    assign res.is_plain = (need == '0);
    assign res.done     = (idx_inc >= need);

endmodule

// ----- hdl/pcfu_seq.sv -----
// ----------------------------------------------------------------------------
// pcfu_seq
// Sequencer: holds the unpacked command queue, walks it one entry per cycle
// via the shared lookup unit unless output stalls, feeding the output stage.
// One result is held back until the next step shows whether it is the last.
// ----------------------------------------------------------------------------
module pcfu_seq (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [pcfu_pkg::WORD_W-1:0] in_word,
    input  logic                        can_push,
    output logic                        push,
    output pcfu_pkg::result_t           push_res,
    output logic                        push_last
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_PARAM = 3'b010,
        ST_SCAN  = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [pcfu_pkg::CMD_W-1:0]  queue_mem [pcfu_pkg::CMDS_PER_WORD];
    logic [pcfu_pkg::POS_W-1:0]  pos_reg, pos_next;
    logic [pcfu_pkg::IDX_W-1:0]  cnt_reg, cnt_next;
    logic                        loaded_reg, loaded_next;
    logic [pcfu_pkg::WORD_W-1:0] word_reg;
    logic                        pend_valid_reg, pend_valid_next;
    pcfu_pkg::result_t           pend_reg, pend_next;

    logic                        accept;
    logic                        at_end;
    logic [pcfu_pkg::CMD_W-1:0]  cur_op;
    pcfu_pkg::need_res_t         nres;

    assign accept = in_valid && in_ready;
    assign in_ready = (state_reg == ST_IDLE);
    assign at_end = (pos_reg == pcfu_pkg::POS_W'(pcfu_pkg::CMDS_PER_WORD));
    assign cur_op = queue_mem[pos_reg[pcfu_pkg::QIDX_W-1:0]];

    pcfu_need u_need (
        .op  (cur_op),
        .idx (cnt_reg),
        .res (nres)
    );

    always_comb begin
        state_next      = state_reg;
        pos_next        = pos_reg;
        cnt_next        = cnt_reg;
        loaded_next     = loaded_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        push            = 1'b0;
        push_last       = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (!loaded_reg) begin
                        pos_next        = '0;
                        cnt_next        = '0;
                        loaded_next     = 1'b1;
                        pend_valid_next = 1'b0;
                        state_next      = ST_SCAN;
                    end else begin
                        state_next = ST_PARAM;
                    end
                end
            end
            ST_PARAM: begin
                pend_next.command      = cur_op;
                pend_next.has_param    = 1'b1;
                pend_next.param_word   = word_reg;
                pend_next.param_index  = cnt_reg;
                pend_next.command_done = nres.done;
                pend_valid_next        = 1'b1;
                if (nres.done) begin
                    cnt_next = '0;
                    pos_next = pos_reg + 1'b1;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
                // an unfinished command stops the scan at once
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if (!at_end && nres.is_plain) begin
                    if (!pend_valid_reg || can_push) begin
                        push                   = pend_valid_reg;
                        pend_next.command      = cur_op;
                        pend_next.has_param    = 1'b0;
                        pend_next.param_word   = '0;
                        pend_next.param_index  = '0;
                        pend_next.command_done = 1'b1;
                        pend_valid_next        = 1'b1;
                        pos_next               = pos_reg + 1'b1;
                    end
                end else if (!pend_valid_reg || can_push) begin
                    push            = pend_valid_reg;
                    push_last       = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                    if (at_end) begin
                        loaded_next = 1'b0;
                        pos_next    = '0;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign push_res = pend_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            pos_reg        <= '0;
            cnt_reg        <= '0;
            loaded_reg     <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            pos_reg        <= pos_next;
            cnt_reg        <= cnt_next;
            loaded_reg     <= loaded_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_reg <= pend_next;
        if (accept) begin
            word_reg <= in_word;
        end
        if (accept && !loaded_reg) begin
            for (int i = 0; i < pcfu_pkg::CMDS_PER_WORD; i++) begin
                queue_mem[i] <= in_word[i*pcfu_pkg::CMD_W +: pcfu_pkg::CMD_W];
            end
        end
    end

endmodule

// ----- hdl/packed_command_fifo_unpacker_core.sv -----
// ----------------------------------------------------------------------------
// packed_command_fifo_unpacker_core
// Splits geometry command FIFO words into command and parameter requests.
// ----------------------------------------------------------------------------
// A word taken while no commands are pending is four packed command bytes,
// low byte first; any leading parameterless commands come out at once, one
// request per cycle unless the output stalls. Each later word is a parameter
// of the current command and comes out with its index and an end-of-command
// flag, followed by any parameterless commands behind it. m_tlast marks the
// final request a word causes; a word that causes none gives no request. The
// queue is walked by a sequencer through one shared table lookup, one entry
// per cycle unless the output stalls, and s_tready stays low until the word
// is done with.
module packed_command_fifo_unpacker_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [pcfu_pkg::WORD_W-1:0]    s_tdata,   // [31:0] word
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [7:0] command, [39:8] param_word, [44:40] param_index, [45] command_done
    output logic [pcfu_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                           m_tuser,   // [0] has_param
    output logic                           m_tlast
);

    logic              m_tvalid_reg;
    pcfu_pkg::result_t m_res_reg;
    logic              m_tlast_reg;
    logic              can_push;
    logic              push;
    logic              push_last;
    pcfu_pkg::result_t push_res;

    assign can_push = !m_tvalid_reg || m_tready;

    pcfu_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_word   (s_tdata),
        .can_push  (can_push),
        .push      (push),
        .push_res  (push_res),
        .push_last (push_last)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (push) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            m_res_reg   <= push_res;
            m_tlast_reg <= push_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_res_reg.has_param;
    assign m_tlast  = m_tlast_reg;
    assign m_tdata  = {2'b00, m_res_reg.command_done, m_res_reg.param_index,
                       m_res_reg.param_word, m_res_reg.command};

endmodule

// ----- hdl/pcfu_checker.sv -----
// ----------------------------------------------------------------------------
// pcfu_checker
// Port-level checks for the packed command FIFO unpacker.
// ----------------------------------------------------------------------------
module pcfu_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [pcfu_pkg::WORD_W-1:0]    s_tdata,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [pcfu_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                           m_tuser,
    input logic                           m_tlast
);

    logic s_req;
    assign s_req = s_tvalid && s_tready && (s_tdata == s_tdata);

    // a stalled request must hold
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("m_* request changed under stall");

    // parameterless command: no payload, always completes
    a_plain_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[39:8] == '0 && m_tdata[44:40] == '0
            && m_tdata[45])
        else $error("parameterless request carries payload");

    // no word is taken in the cycle right after one was taken
    a_busy_after_req: assert property (@(posedge aclk) disable iff (!aresetn)
        s_req |=> !s_tready)
        else $error("input taken on back-to-back cycles");

    // nothing shows on the output right after reset
    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

endmodule

bind packed_command_fifo_unpacker_core pcfu_checker u_pcfu_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ----- bench/unpack_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unpack_checker
// Watches both stream channels of the command FIFO unpacker, predicts the
// requests each accepted FIFO word releases and compares them in order.
// ----------------------------------------------------------------------------
module unpack_checker
    import pcfu_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [WORD_W-1:0]     s_tdata,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  m_tuser,
    input  logic                  m_tlast,
    output int                    fail_count,
    output int                    pending
);

    typedef struct {
        logic [CMD_W-1:0]  command;
        logic              has_param;
        logic [WORD_W-1:0] param_word;
        logic [IDX_W-1:0]  param_index;
        logic              command_done;
        logic              last;
    } request_t;

    request_t          request_q[$];

    // shadow of the block's command queue
    logic [CMD_W-1:0]  cmd_slot [CMDS_PER_WORD];
    int                slot_pos;
    bit                slots_live;
    logic [NEED_W-1:0] params_seen;

    function automatic int arg_count(input logic [CMD_W-1:0] op);
        case (op)
            CMD_NOP, CMD_MTX_PUSH, CMD_MTX_IDENT, CMD_END_VTXS: return 0;
            CMD_MTX_LOAD44, CMD_MTX_MUL44:                      return 16;
            CMD_MTX_LOAD43, CMD_MTX_MUL43:                      return 12;
            CMD_MTX_MUL33:                                      return 9;
            CMD_MTX_SCALE, CMD_MTX_TRANS, CMD_BOX_TEST:         return 3;
            CMD_VTX_16, CMD_POS_TEST:                           return 2;
            CMD_SHIN_TABLE:                                     return 32;
            default:                                            return 1;
        endcase
    endfunction

    task automatic predict_word(input logic [WORD_W-1:0] w);
        request_t batch[$];
        request_t r;
        int       need;
        int       i;
        bit       walk;
        walk = 1'b1;
        if (!slots_live) begin
            for (i = 0; i < CMDS_PER_WORD; i++) cmd_slot[i] = w[8*i +: 8];
            slots_live  = 1'b1;
            slot_pos    = 0;
            params_seen = '0;
        end else begin
            need           = arg_count(cmd_slot[slot_pos]);
            r.command      = cmd_slot[slot_pos];
            r.has_param    = 1'b1;
            r.param_word   = w;
            r.param_index  = params_seen[IDX_W-1:0];
            r.command_done = (int'(params_seen) + 1 >= need);
            r.last         = 1'b0;
            batch = {batch, r};
            if (r.command_done) begin
                params_seen = '0;
                slot_pos++;
            end else begin
                params_seen = params_seen + 1'b1;
                walk = 1'b0;
            end
        end
        // parameterless commands behind the current one go out right away
        if (walk) begin
            while (slot_pos < CMDS_PER_WORD && arg_count(cmd_slot[slot_pos]) == 0) begin
                r.command      = cmd_slot[slot_pos];
                r.has_param    = 1'b0;
                r.param_word   = '0;
                r.param_index  = '0;
                r.command_done = 1'b1;
                r.last         = 1'b0;
                batch = {batch, r};
                slot_pos++;
            end
            if (slot_pos >= CMDS_PER_WORD) begin
                slots_live = 1'b0;
                slot_pos   = 0;
            end
        end
        if (batch.size() > 0) batch[$].last = 1'b1;
        request_q = {request_q, batch};
    endtask

    task automatic check_field(input string name, input logic [WORD_W-1:0] want,
                               input logic [WORD_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    initial begin
        fail_count = 0;
    end

    always @(posedge aclk) begin
        request_t want;
        if (!aresetn) begin
            request_q.delete();
            slot_pos    = 0;
            slots_live  = 1'b0;
            params_seen = '0;
        end else begin
            // input side first: a request leaving on this edge is always older
            if (s_tvalid && s_tready) predict_word(s_tdata);
            if (m_tvalid && m_tready) begin
                if (request_q.size() == 0) begin
                    $error("unexpected request: command %0h", m_tdata[7:0]);
                    fail_count++;
                end else begin
                    want = request_q.pop_front();
                    check_field("command",      WORD_W'(want.command),
                                WORD_W'(m_tdata[7:0]));
                    check_field("has_param",    WORD_W'(want.has_param),
                                WORD_W'(m_tuser));
                    check_field("param_word",   want.param_word,   m_tdata[39:8]);
                    check_field("param_index",  WORD_W'(want.param_index),
                                WORD_W'(m_tdata[44:40]));
                    check_field("command_done", WORD_W'(want.command_done),
                                WORD_W'(m_tdata[45]));
                    check_field("last",         WORD_W'(want.last),
                                WORD_W'(m_tlast));
                end
            end
        end
        pending = request_q.size();
    end

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the packed command FIFO unpacker: directed command words and
// parameter runs, then random well-formed command streams with random stalls
// on both channels. Checking is done by unpack_checker.
// ----------------------------------------------------------------------------
module testbench;
    import pcfu_pkg::*;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [WORD_W-1:0]    s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;
    logic                 m_tlast;
    int                   fail_count;
    int                   pending;

    int                   words_sent = 0;
    bit                   tx_burst = 1'b0;
    int                   rx_mode = 0;
    int                   rx_mode_left = 0;
    int                   ready_hold = 0;

    logic [CMD_W-1:0] plain_cmds [4] = '{CMD_NOP, CMD_MTX_PUSH, CMD_MTX_IDENT, CMD_END_VTXS};
    logic [CMD_W-1:0] short_cmds [5] = '{CMD_MTX_SCALE, CMD_MTX_TRANS, CMD_BOX_TEST,
                                         CMD_VTX_16, CMD_POS_TEST};
    logic [CMD_W-1:0] long_cmds  [6] = '{CMD_MTX_LOAD44, CMD_MTX_LOAD43, CMD_MTX_MUL44,
                                         CMD_MTX_MUL43, CMD_MTX_MUL33, CMD_SHIN_TABLE};

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    packed_command_fifo_unpacker_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    unpack_checker u_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // number of parameter words to send after a command byte
    function automatic int param_words_for(input logic [CMD_W-1:0] op);
        case (op)
            CMD_NOP, CMD_MTX_PUSH, CMD_MTX_IDENT, CMD_END_VTXS: return 0;
            CMD_MTX_LOAD44, CMD_MTX_MUL44:                      return 16;
            CMD_MTX_LOAD43, CMD_MTX_MUL43:                      return 12;
            CMD_MTX_MUL33:                                      return 9;
            CMD_MTX_SCALE, CMD_MTX_TRANS, CMD_BOX_TEST:         return 3;
            CMD_VTX_16, CMD_POS_TEST:                           return 2;
            CMD_SHIN_TABLE:                                     return 32;
            default:                                            return 1;
        endcase
    endfunction

    function automatic logic [CMD_W-1:0] pick_command();
        int r;
        r = $urandom_range(99);
        if (r < 35) return plain_cmds[$urandom_range(3)];
        if (r < 70) return short_cmds[$urandom_range(4)];
        if (r < 76) return long_cmds[$urandom_range(5)];
        return CMD_W'($urandom);
    endfunction

    function automatic logic [WORD_W-1:0] param_value();
        int r;
        r = $urandom_range(99);
        if (r < 5) return '0;
        if (r < 10) return '1;
        return $urandom;
    endfunction

    function automatic int pick_gap();
        int r;
        if (tx_burst) return 0;
        r = $urandom_range(99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic push_word(input logic [WORD_W-1:0] w);
        int gap;
        gap = pick_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        do @(posedge aclk); while (!s_tready);
        words_sent++;
    endtask

    // command word followed by the parameter words its commands take
    task automatic push_packet(input logic [WORD_W-1:0] cw);
        int i;
        push_word(cw);
        for (i = 0; i < CMDS_PER_WORD; i++)
            repeat (param_words_for(cw[8*i +: 8])) push_word(param_value());
    endtask

    // receiver: stretches of full readiness, short stalls, and a few long ones
    always @(negedge aclk) begin
        if (rx_mode_left == 0) begin
            rx_mode      = $urandom_range(2);
            rx_mode_left = $urandom_range(20, 100);
        end else begin
            rx_mode_left--;
        end
        if (ready_hold > 0) begin
            ready_hold--;
            m_tready <= 1'b0;
        end else if (rx_mode == 0 || $urandom_range(99) >= 30) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= 1'b0;
            ready_hold = (rx_mode == 2 && $urandom_range(9) == 0) ?
                         $urandom_range(10, 40) : $urandom_range(0, 2);
        end
    end

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // all four parameterless: four requests, block stays idle
        push_packet({CMD_END_VTXS, CMD_MTX_IDENT, CMD_MTX_PUSH, CMD_NOP});
        // unknown bytes only: load gives nothing, then one parameter each
        push_word('1);
        push_word('0);
        push_word('1);
        push_word(32'hA5A5_A5A5);
        push_word(32'h5A5A_5A5A);
        // plain lead, a three-parameter command, then a plain tail
        push_word({CMD_END_VTXS, CMD_NOP, CMD_MTX_SCALE, CMD_MTX_PUSH});
        push_word(32'h0000_0001);
        push_word(32'h8000_0000);
        push_word(32'h7FFF_FFFF);
        // two-parameter commands separated by a plain one
        push_word({CMD_NOP, CMD_POS_TEST, CMD_NOP, CMD_VTX_16});
        push_word('0);
        push_word('1);
        push_word(32'h1234_5678);
        push_word(32'hFEDC_BA98);

        while (words_sent < 245) begin
            tx_burst = ($urandom_range(3) == 0);
            if ($urandom_range(9) == 0) begin
                push_packet($urandom);
            end else begin
                push_packet({pick_command(), pick_command(), pick_command(), pick_command()});
            end
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
